[hw/rtl/abtf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abtf_pkg: shared types and constants
// Request/result structs, mode and kind codes for the affine texel fetch.
// ----------------------------------------------------------------------------
package abtf_pkg;

  localparam int LinePixels = 256;
  localparam int FracBits   = 8;
  localparam int AccW       = 28;
  localparam int ColW       = 9;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_PIXEL = 2'd1;
  localparam logic [1:0] REQ_DATA  = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;

  localparam logic [2:0] KIND_ACK   = 3'd0;
  localparam logic [2:0] KIND_SKIP  = 3'd1;
  localparam logic [2:0] KIND_TRANS = 3'd2;
  localparam logic [2:0] KIND_READ  = 3'd3;
  localparam logic [2:0] KIND_OPAQ  = 3'd4;
  localparam logic [2:0] KIND_ERR   = 3'd5;

  localparam logic [2:0] MODE_AFFINE = 3'd0;
  localparam logic [2:0] MODE_EXT    = 3'd1;
  localparam logic [2:0] MODE_BMP8   = 3'd2;
  localparam logic [2:0] MODE_DIRECT = 3'd3;
  localparam logic [2:0] MODE_LARGE  = 3'd4;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_SIZE   = 3'd1;
  localparam logic [2:0] REG_WRAP   = 3'd2;
  localparam logic [2:0] REG_MOSAIC = 3'd3;
  localparam logic [2:0] REG_MAP    = 3'd4;
  localparam logic [2:0] REG_TILE   = 3'd5;
  localparam logic [2:0] REG_STEPX  = 3'd6;
  localparam logic [2:0] REG_STEPY  = 3'd7;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ENTRY = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic               in_window;
    logic signed [27:0] line_ref_x;
    logic signed [27:0] line_ref_y;
    logic [15:0]        read_data;
  } req_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [19:0] read_address;
    logic        read_halfword;
    logic [7:0]  pixel_x;
    logic [15:0] color_value;
    logic [3:0]  pal_num;
  } res_t;

  typedef struct packed {
    logic [2:0]         bg_mode;
    logic [1:0]         size_select;
    logic               wrap_enable;
    logic [3:0]         mosaic_minus_one;
    logic [18:0]        map_base;
    logic [18:0]        tile_base;
    logic signed [15:0] step_x;
    logic signed [15:0] step_y;
  } cfg_t;

  // Classified pixel work passed from front to back.
  typedef struct packed {
    logic [1:0]  op;      // REQ_* code
    logic        skip;    // pixel skipped (window, bounds or line end)
    logic        err;
    logic [7:0]  px;
    logic [10:0] tx;      // texel, already known in range
    logic [10:0] ty;
    logic [15:0] data;
  } work_t;

endpackage

[hw/rtl/abtf_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abtf_front: request intake and texel classification
// Holds the accumulators and column, turns each pixel into a texel position.
// ----------------------------------------------------------------------------
module abtf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  abtf_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  input  abtf_pkg::req_t in_data_i,
  output logic           in_stall_o,
  output logic           wk_valid_o,
  output abtf_pkg::work_t wk_data_o,
  input  logic           wk_stall_i
);
  import abtf_pkg::*;

  logic [AccW-1:0] acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic [ColW-1:0] col_q, col_d;
  logic            wv_q;
  work_t           wk_q, wk_d;
  logic            take;

  logic [10:0] w, h;
  logic        err, oob;
  logic signed [19:0] tx, ty;
  logic [4:0]  m;
  logic [3:0]  rem_q [16];
  logic [3:0]  rem_d [16];
  logic signed [20:0] mx, my;

  assign in_stall_o = wv_q & wk_stall_i;
  assign take = in_valid_i & ~in_stall_o;
  assign wk_valid_o = wv_q;
  assign wk_data_o = wk_q;

  always_comb begin
    w = 11'd128; h = 11'd128; err = 1'b0;
    if (cfg_i.bg_mode <= MODE_EXT) begin
      w = 11'd128 << cfg_i.size_select; h = w;
    end else if (cfg_i.bg_mode <= MODE_DIRECT) begin
      case (cfg_i.size_select)
        2'd0: begin w = 11'd128; h = 11'd128; end
        2'd1: begin w = 11'd256; h = 11'd256; end
        2'd2: begin w = 11'd512; h = 11'd256; end
        default: begin w = 11'd512; h = 11'd512; end
      endcase
    end else if (cfg_i.bg_mode == MODE_LARGE && !cfg_i.size_select[1]) begin
      w = cfg_i.size_select[0] ? 11'd1024 : 11'd512;
      h = cfg_i.size_select[0] ? 11'd512 : 11'd1024;
    end else begin
      err = 1'b1;
    end
    tx = 20'(signed'(acc_x_q) >>> FracBits);
    ty = 20'(signed'(acc_y_q) >>> FracBits);
    oob = tx[19] || ty[19] || (tx >= signed'({9'd0, w})) || (ty >= signed'({9'd0, h}));
  end

  // mosaic: rem_q[k] holds column mod (k+1) for every width, so no divider
  // is needed and a width change mid-line still lands on the right pixel
  assign m  = {1'b0, cfg_i.mosaic_minus_one} + 5'd1;
  assign mx = 21'(signed'({1'b0, m}) * cfg_i.step_x);
  assign my = 21'(signed'({1'b0, m}) * cfg_i.step_y);

  always_comb begin
    acc_x_d = acc_x_q; acc_y_d = acc_y_q; col_d = col_q; rem_d = rem_q;
    wk_d = wk_q;
    if (take) begin
      wk_d.op = in_data_i.req_type;
      wk_d.data = in_data_i.read_data;
      wk_d.skip = 1'b0; wk_d.err = 1'b0;
      wk_d.px = col_q[7:0];
      wk_d.tx = tx[10:0] & (cfg_i.wrap_enable ? w - 11'd1 : 11'h7FF);
      wk_d.ty = ty[10:0] & (cfg_i.wrap_enable ? h - 11'd1 : 11'h7FF);
      if (in_data_i.req_type == REQ_START) begin
        acc_x_d = in_data_i.line_ref_x; acc_y_d = in_data_i.line_ref_y;
        col_d = '0;
        for (int k = 0; k < 16; k++) rem_d[k] = 4'd0;
      end else if (in_data_i.req_type == REQ_PIXEL) begin
        if (col_q >= ColW'(LinePixels)) begin
          wk_d.skip = 1'b1;
        end else begin
          col_d = col_q + 1'b1;
          if (cfg_i.mosaic_minus_one == 4'd0) begin
            acc_x_d = acc_x_q + AccW'(cfg_i.step_x);
            acc_y_d = acc_y_q + AccW'(cfg_i.step_y);
          end else if (rem_q[cfg_i.mosaic_minus_one] == cfg_i.mosaic_minus_one) begin
            // new column is a multiple of the mosaic width
            acc_x_d = acc_x_q + AccW'(mx);
            acc_y_d = acc_y_q + AccW'(my);
          end
          for (int k = 0; k < 16; k++) begin
            rem_d[k] = (rem_q[k] == 4'(k)) ? 4'd0 : rem_q[k] + 4'd1;
          end
          wk_d.err = err;
          wk_d.skip = !in_data_i.in_window || (!cfg_i.wrap_enable && oob);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q <= '0; acc_y_q <= '0; col_q <= '0; wv_q <= 1'b0;
      for (int k = 0; k < 16; k++) rem_q[k] <= 4'd0;
    end else begin
      acc_x_q <= acc_x_d; acc_y_q <= acc_y_d; col_q <= col_d; rem_q <= rem_d;
      if (take) wv_q <= 1'b1;
      else if (!wk_stall_i) wv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    wk_q <= wk_d;
  end
endmodule

[hw/rtl/abtf_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abtf_back: address and pixel generation
// Tracks the fetch phase, forms read addresses and final pixel results.
// ----------------------------------------------------------------------------
module abtf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  abtf_pkg::cfg_t  cfg_i,
  input  logic            wk_valid_i,
  input  abtf_pkg::work_t wk_data_i,
  output logic            wk_stall_o,
  output logic            out_valid_o,
  output abtf_pkg::res_t  out_data_o,
  input  logic            out_stall_i
);
  import abtf_pkg::*;

  logic [1:0]  ph_q, ph_d;
  logic [9:0]  tx_q, ty_q;
  logic [3:0]  pal_q, pal_d;
  logic [7:0]  px_q;
  logic        ov_q;
  res_t        res_q, res_d;
  logic        take;
  logic [10:0] w;
  logic [19:0] lin;
  logic [9:0]  idx;
  logic [2:0]  fx, fy;

  assign wk_stall_o  = ov_q & out_stall_i;
  assign take        = wk_valid_i & ~wk_stall_o;
  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;

  always_comb begin
    case (cfg_i.size_select)
      2'd0: w = 11'd128;
      2'd1: w = 11'd256;
      default: w = 11'd512;
    endcase
    if (cfg_i.bg_mode <= MODE_EXT) w = 11'd128 << cfg_i.size_select;
    if (cfg_i.bg_mode == MODE_LARGE) w = cfg_i.size_select[0] ? 11'd1024 : 11'd512;
  end

  // one multiply: row offset; width is a power of two so this is a shift
  assign lin = 20'(w * wk_data_i.ty[9:0]) + 20'(wk_data_i.tx[9:0]);

  always_comb begin
    fx = tx_q[2:0]; fy = ty_q[2:0];
    if (cfg_i.bg_mode == MODE_EXT) begin
      if (wk_data_i.data[11]) fy = 3'd7 - fy;
      if (wk_data_i.data[10]) fx = 3'd7 - fx;
      idx = wk_data_i.data[9:0];
    end else begin
      idx = {2'b0, wk_data_i.data[7:0]};
    end
  end

  always_comb begin
    ph_d = ph_q; pal_d = pal_q; res_d = '0;
    case (wk_data_i.op)
      REQ_START: ph_d = PH_IDLE;
      REQ_PIXEL: begin
        ph_d = PH_IDLE;
        res_d.pixel_x = wk_data_i.px;
        if (wk_data_i.err) res_d.result_kind = KIND_ERR;
        else if (wk_data_i.skip) res_d.result_kind = KIND_SKIP;
        else begin
          res_d.result_kind = KIND_READ;
          pal_d = '0;
          case (cfg_i.bg_mode)
            MODE_AFFINE: begin
              res_d.read_address = 20'(cfg_i.map_base)
                + 20'((w >> 3) * wk_data_i.ty[9:3]) + 20'(wk_data_i.tx[9:3]);
              ph_d = PH_ENTRY;
            end
            MODE_EXT: begin
              res_d.read_address = 20'(cfg_i.map_base)
                + 20'((w >> 2) * wk_data_i.ty[9:3]) + 20'({wk_data_i.tx[9:3], 1'b0});
              res_d.read_halfword = 1'b1; ph_d = PH_ENTRY;
            end
            MODE_BMP8: begin
              res_d.read_address = 20'(cfg_i.map_base) + lin; ph_d = PH_DATA;
            end
            MODE_DIRECT: begin
              res_d.read_address = 20'(cfg_i.map_base) + {lin[18:0], 1'b0};
              res_d.read_halfword = 1'b1; ph_d = PH_DATA;
            end
            default: begin
              res_d.read_address = lin; ph_d = PH_DATA;
            end
          endcase
        end
      end
      REQ_DATA: begin
        if (ph_q == PH_ENTRY) begin
          res_d.result_kind = KIND_READ;
          res_d.pixel_x = px_q;
          res_d.read_address = 20'(cfg_i.tile_base) + 20'({idx, 6'd0})
            + 20'({fy, fx});
          pal_d = (cfg_i.bg_mode == MODE_EXT) ? wk_data_i.data[15:12] : 4'd0;
          ph_d = PH_DATA;
        end else if (ph_q == PH_DATA) begin
          ph_d = PH_IDLE;
          res_d.pixel_x = px_q;
          if (cfg_i.bg_mode == MODE_DIRECT) begin
            if (!wk_data_i.data[15]) res_d.result_kind = KIND_TRANS;
            else begin
              res_d.result_kind = KIND_OPAQ; res_d.color_value = wk_data_i.data;
            end
          end else if (wk_data_i.data[7:0] == 8'd0) begin
            res_d.result_kind = KIND_TRANS;
          end else begin
            res_d.result_kind = KIND_OPAQ;
            res_d.color_value = {8'd0, wk_data_i.data[7:0]};
            res_d.pal_num = (cfg_i.bg_mode == MODE_EXT) ? pal_q : 4'd0;
          end
        end else begin
          res_d.result_kind = KIND_ACK;
        end
      end
      default: res_d.result_kind = KIND_ACK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; pal_q <= '0; ov_q <= 1'b0;
      tx_q <= '0; ty_q <= '0; px_q <= '0;
    end else begin
      if (take) begin
        ph_q <= ph_d; pal_q <= pal_d; ov_q <= 1'b1;
        if (wk_data_i.op == REQ_PIXEL && ph_d != PH_IDLE) begin
          tx_q <= wk_data_i.tx[9:0]; ty_q <= wk_data_i.ty[9:0];
          px_q <= wk_data_i.px;
        end
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end
endmodule

[hw/rtl/affine_background_texel_fetch.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_background_texel_fetch: affine background fetch for one scanline
// Front classifies pixels against the background size, back issues reads.
// ----------------------------------------------------------------------------
// One request is accepted and one result leaves per cycle when neither side
// stalls. A start-line request loads the signed 20.8 reference point; each
// pixel request yields a skip, a size error or a video-memory read request;
// each data return yields the next read, the final pixel or an acknowledge.
// The front stage has one register (texel position, window and bounds check,
// accumulator step), the back stage one result register (phase tracking and
// address formation). The front register acts as the one-entry queue between
// the stages, so the back can stall without losing a classified request. The
// user must write configuration only while idle (not enforced here).
// ----------------------------------------------------------------------------
module affine_background_texel_fetch (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  abtf_pkg::req_t in_data_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  output abtf_pkg::res_t out_data_o,
  input  logic           out_stall_i,
  input  logic           cfg_valid_i,
  input  logic [2:0]     cfg_index_i,
  input  logic [31:0]    cfg_data_i,
  output logic           cfg_ready_o
);
  import abtf_pkg::*;

  cfg_t  cfg_q;
  logic  wk_valid, wk_stall;
  work_t wk_data;

  assign cfg_ready_o = 1'b1;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{step_x: 16'sd256, default: '0};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:   cfg_q.bg_mode <= cfg_data_i[2:0];
        REG_SIZE:   cfg_q.size_select <= cfg_data_i[1:0];
        REG_WRAP:   cfg_q.wrap_enable <= cfg_data_i[0];
        REG_MOSAIC: cfg_q.mosaic_minus_one <= cfg_data_i[3:0];
        REG_MAP:    cfg_q.map_base <= cfg_data_i[18:0];
        REG_TILE:   cfg_q.tile_base <= cfg_data_i[18:0];
        REG_STEPX:  cfg_q.step_x <= cfg_data_i[15:0];
        REG_STEPY:  cfg_q.step_y <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  abtf_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .in_valid_i, .in_data_i, .in_stall_o,
    .wk_valid_o(wk_valid), .wk_data_o(wk_data), .wk_stall_i(wk_stall)
  );

  abtf_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .wk_valid_i(wk_valid), .wk_data_i(wk_data), .wk_stall_o(wk_stall),
    .out_valid_o, .out_data_o, .out_stall_i
  );
endmodule
